/* hw/rtl/pcs_pkg.sv */
// Shared types, widths and helpers for the projection character segmenter.
// Used by pcs_tracker, pcs_span and projection_char_segmenter_core.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

    // Image geometry limits
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 1024;

    // Field widths
    localparam int INK_W   = 64;
    localparam int COL_W   = 10;
    localparam int ECOL_W  = 11;
    localparam int ROW_W   = 6;
    localparam int EROW_W  = 7;
    localparam int CHAR_W  = 6;
    localparam int CFG_W   = 10;

    // Configuration register indexes
    localparam logic CFG_FIRST_COLUMN = 1'b0;
    localparam logic CFG_ROWS_IN_USE  = 1'b1;

    localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(MAX_COLS - 1);
    localparam logic [CHAR_W-1:0] CHAR_SAT  = '1;
    localparam logic [EROW_W-1:0] ROWS_FULL = EROW_W'(MAX_ROWS);

    // Result descriptor handed from the tracker to the output stage
    typedef struct packed {
        logic              vld;
        logic [CHAR_W-1:0] index;
        logic [COL_W-1:0]  start_col;
        logic [ECOL_W-1:0] end_col;
        logic              open_edge;
    } t_emit;

    // Image height clamped to 1..MAX_ROWS
    function automatic logic [EROW_W-1:0] eff_rows(input logic [EROW_W-1:0] rows);
        logic [EROW_W-1:0] r;
        r = rows;
        if (r == '0) begin
            r = EROW_W'(1);
        end else if (r > ROWS_FULL) begin
            r = ROWS_FULL;
        end
        return r;
    endfunction

    // Mask of rows below the effective height
    function automatic logic [INK_W-1:0] row_mask(input logic [EROW_W-1:0] rows);
        logic [INK_W-1:0] m;
        for (int i = 0; i < INK_W; i++) begin
            m[i] = (EROW_W'(i) < rows);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/pcs_span.sv */
// Row span finder: first inked row and first empty row after it.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcs_span (
    input  wire logic [pcs_pkg::INK_W-1:0]  i_union,
    output logic      [pcs_pkg::ROW_W-1:0]  o_top_row,
    output logic      [pcs_pkg::EROW_W-1:0] o_end_row
);
    import pcs_pkg::*;

    logic [INK_W-1:0]  shifted;
    logic [EROW_W-1:0] first_zero;

    // Priority encode the lowest set bit; union is never empty on a result
    always_comb begin
        o_top_row = '0;
        for (int i = INK_W - 1; i >= 0; i--) begin
            if (i_union[i]) begin
                o_top_row = ROW_W'(i);
            end
        end
    end

    // Rows above the height are already masked off, and the shift fills zeros,
    // so the first clear bit never lands past the height
    assign shifted = i_union >> o_top_row;

    always_comb begin
        first_zero = EROW_W'(INK_W);
        for (int i = INK_W - 1; i >= 0; i--) begin
            if (!shifted[i]) begin
                first_zero = EROW_W'(i);
            end
        end
    end

    assign o_end_row = EROW_W'({1'b0, o_top_row}) + first_zero;

endmodule

`default_nettype wire

/* hw/rtl/pcs_tracker.sv */
// Column scan state: open/close detection, row union and column counting.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcs_tracker (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_adv,
    input  wire logic [pcs_pkg::INK_W-1:0]  i_mask,
    input  wire logic                       i_last,
    input  wire logic [pcs_pkg::COL_W-1:0]  i_first_col,
    output pcs_pkg::t_emit                  o_emit,
    output logic      [pcs_pkg::INK_W-1:0]  o_union
);
    import pcs_pkg::*;

    logic [COL_W-1:0]  r_col_cnt, n_col_cnt;
    logic              r_inside, n_inside;
    logic [COL_W-1:0]  r_start, n_start;
    logic [INK_W-1:0]  r_union, n_union;
    logic [CHAR_W-1:0] r_chars, n_chars;

    logic              scan, has_ink, close_now, edge_now;
    logic              mid_inside;
    logic [COL_W-1:0]  mid_start;
    logic [INK_W-1:0]  mid_union;

    assign scan    = (r_col_cnt >= i_first_col);
    assign has_ink = (i_mask != '0);

    // Effect of this column before the end-of-image check
    always_comb begin
        mid_inside = r_inside;
        mid_start  = r_start;
        mid_union  = r_union;
        close_now  = 1'b0;
        if (scan) begin
            if (!r_inside) begin
                if (has_ink) begin
                    mid_inside = 1'b1;
                    mid_start  = r_col_cnt;
                    mid_union  = i_mask;
                end
            end else if (!has_ink) begin
                close_now  = 1'b1;
                mid_inside = 1'b0;
            end else begin
                mid_union = r_union | i_mask;
            end
        end
    end

    assign edge_now = i_last && mid_inside;

    // Result descriptor
    always_comb begin
        o_emit.vld       = close_now || edge_now;
        o_emit.index     = r_chars;
        o_emit.start_col = mid_start;
        o_emit.end_col   = close_now ? ECOL_W'(r_col_cnt)
                                     : ECOL_W'(r_col_cnt) + ECOL_W'(1);
        o_emit.open_edge = edge_now;
    end
    assign o_union = mid_union;

    // Next state
    always_comb begin
        if (i_last) begin
            n_col_cnt = '0;
            n_inside  = 1'b0;
            n_start   = '0;
            n_union   = '0;
            n_chars   = '0;
        end else begin
            n_col_cnt = (r_col_cnt < COL_LAST) ? r_col_cnt + COL_W'(1) : r_col_cnt;
            n_inside  = mid_inside;
            n_start   = mid_start;
            n_union   = mid_inside ? mid_union : '0;
            n_chars   = (close_now && r_chars != CHAR_SAT) ? r_chars + CHAR_W'(1)
                                                           : r_chars;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_inside  <= 1'b0;
            r_start   <= '0;
            r_union   <= '0;
            r_chars   <= '0;
        end else if (i_adv) begin
            r_col_cnt <= n_col_cnt;
            r_inside  <= n_inside;
            r_start   <= n_start;
            r_union   <= n_union;
            r_chars   <= n_chars;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/projection_char_segmenter_core.sv */
// Top level of the projection character segmenter: config registers,
// input register, result register. Depends on pcs_pkg, pcs_tracker, pcs_span.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                    Payload
// -------   --------------------------   -------------------------------------
// in        i_in_valid / o_in_stall      i_column_ink, i_last_column
// out       o_out_valid / i_out_stall    o_char_index, o_start_col, o_end_col,
//                                        o_top_row, o_end_row, o_open_at_edge
// cfg       i_cfg_wr_en                  i_cfg_index, i_cfg_wdata
//
// One column item per cycle while the output is not stalled; a column lands in
// the input register, and when the result slot frees up its result, if any,
// loads the result register, which drives o_out_valid.
// Synchronous active-low reset clears the scan state and sets first_column
// to 1 and rows_in_use to 64.
// A stalled output holds the result register; the input register keeps
// taking items until both registers are full.

module projection_char_segmenter_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic [pcs_pkg::INK_W-1:0]   i_column_ink,
    input  wire logic                        i_last_column,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic      [pcs_pkg::CHAR_W-1:0]  o_char_index,
    output logic      [pcs_pkg::COL_W-1:0]   o_start_col,
    output logic      [pcs_pkg::ECOL_W-1:0]  o_end_col,
    output logic      [pcs_pkg::ROW_W-1:0]   o_top_row,
    output logic      [pcs_pkg::EROW_W-1:0]  o_end_row,
    output logic                             o_open_at_edge,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic                        i_cfg_index,
    input  wire logic [pcs_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import pcs_pkg::*;

    logic [COL_W-1:0]  r_first_col;
    logic [EROW_W-1:0] r_rows_in_use;

    logic              r_in_vld;
    logic [INK_W-1:0]  r_ink;
    logic              r_last;

    logic              r_out_vld;

    logic              adv, in_take;
    logic [EROW_W-1:0] rows_eff;
    logic [INK_W-1:0]  mask;
    t_emit             emit;
    logic [INK_W-1:0]  span_union;
    logic [ROW_W-1:0]  top_row;
    logic [EROW_W-1:0] end_row;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_col   <= COL_W'(1);
            r_rows_in_use <= ROWS_FULL;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FIRST_COLUMN: r_first_col   <= i_cfg_wdata[COL_W-1:0];
                CFG_ROWS_IN_USE:  r_rows_in_use <= i_cfg_wdata[EROW_W-1:0];
                default: ;
            endcase
        end
    end

    // Flow control: the work stage advances when the result slot frees up
    assign adv        = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ink  <= i_column_ink;
            r_last <= i_last_column;
        end
    end

    // Ignore rows at and above the image height
    assign rows_eff = eff_rows(r_rows_in_use);
    assign mask     = r_ink & row_mask(rows_eff);

    pcs_tracker u_tracker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_mask      (mask),
        .i_last      (r_last),
        .i_first_col (r_first_col),
        .o_emit      (emit),
        .o_union     (span_union)
    );

    pcs_span u_span (
        .i_union   (span_union),
        .o_top_row (top_row),
        .o_end_row (end_row)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= emit.vld;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && emit.vld) begin
            o_char_index   <= emit.index;
            o_start_col    <= emit.start_col;
            o_end_col      <= emit.end_col;
            o_top_row      <= top_row;
            o_end_row      <= end_row;
            o_open_at_edge <= emit.open_edge;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

`default_nettype wire

/* bench/projection_char_segmenter_core_tb.sv */
// Testbench for projection_char_segmenter_core: drives image columns, predicts the
// character spans in a scoreboard class and checks every result item.
// Depends on pcs_pkg and the segmenter RTL.
`timescale 1ns / 1ps

module projection_char_segmenter_core_tb;
    import pcs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // Page shapes for the column generator
    localparam int PAGE_TEXT  = 0;
    localparam int PAGE_DENSE = 1;
    localparam int PAGE_NOISE = 2;

    typedef struct {
        logic [CHAR_W-1:0] char_index;
        logic [COL_W-1:0]  start_col;
        logic [ECOL_W-1:0] end_col;
        logic [ROW_W-1:0]  top_row;
        logic [EROW_W-1:0] end_row;
        logic              open_edge;
    } t_span;

    // Span predictor and store of expected spans
    class span_tracker;
        t_span             pending[$];
        int                errors;
        logic [COL_W-1:0]  first_col;
        logic [EROW_W-1:0] rows_cfg;
        logic [COL_W-1:0]  col_idx;
        bit                in_char;
        logic [COL_W-1:0]  char_start;
        logic [INK_W-1:0]  ink_union;
        logic [CHAR_W-1:0] char_count;

        function new();
            errors = 0;
            first_col = COL_W'(1);
            rows_cfg = ROWS_FULL;
            clear_scan();
        endfunction

        function void clear_scan();
            col_idx = '0;
            in_char = 0;
            char_start = '0;
            ink_union = '0;
            char_count = '0;
        endfunction

        function void write_reg(logic idx, logic [CFG_W-1:0] data);
            if (idx == CFG_FIRST_COLUMN) begin
                first_col = data[COL_W-1:0];
            end else begin
                rows_cfg = data[EROW_W-1:0];
            end
        endfunction

        // Height clamped to 1..MAX_ROWS
        function int height();
            int r;
            r = rows_cfg;
            if (r == 0) begin
                r = 1;
            end else if (r > MAX_ROWS) begin
                r = MAX_ROWS;
            end
            return r;
        endfunction

        // Close the open character and queue its span
        function void close_char(logic [ECOL_W-1:0] end_c, bit at_edge);
            t_span s;
            int h, top, bot;
            h = height();
            top = 0;
            while (top < h && !ink_union[top]) top++;
            if (top >= h) top = 0;
            bot = top;
            while (bot < h && ink_union[bot]) bot++;
            s.char_index = char_count;
            s.start_col = char_start;
            s.end_col = end_c;
            s.top_row = top[ROW_W-1:0];
            s.end_row = bot[EROW_W-1:0];
            s.open_edge = at_edge;
            pending.push_back(s);
            if (char_count < CHAR_SAT) char_count++;
            in_char = 0;
            ink_union = '0;
        endfunction

        function void take_column(logic [INK_W-1:0] ink, logic is_last);
            logic [INK_W-1:0] vis;
            logic [COL_W-1:0] idx;
            int h;
            h = height();
            for (int i = 0; i < INK_W; i++) vis[i] = ink[i] && (i < h);
            idx = col_idx;
            if (idx >= first_col) begin
                if (!in_char) begin
                    if (vis != '0) begin
                        in_char = 1;
                        char_start = idx;
                        ink_union = vis;
                    end
                end else if (vis == '0) begin
                    close_char({1'b0, idx}, 0);
                end else begin
                    ink_union |= vis;
                end
            end
            // end of page: flag a character still open, restart counting
            if (is_last) begin
                if (in_char) close_char({1'b0, idx} + ECOL_W'(1), 1);
                clear_scan();
            end else if (col_idx < COL_LAST) begin
                col_idx++;
            end
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                errors++;
            end
        endfunction

        function void match_span(t_span got);
            t_span want;
            if (pending.size() == 0) begin
                $display("%0t: result with nothing expected, expected none, actual start_col %0d",
                         $time, got.start_col);
                errors++;
                return;
            end
            want = pending.pop_front();
            check_field("char_index", want.char_index, got.char_index);
            check_field("start_col", want.start_col, got.start_col);
            check_field("end_col", want.end_col, got.end_col);
            check_field("top_row", want.top_row, got.top_row);
            check_field("end_row", want.end_row, got.end_row);
            check_field("open_at_edge", want.open_edge, got.open_edge);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    logic [INK_W-1:0]    i_column_ink;
    logic                i_last_column;
    logic                o_out_valid;
    logic                i_out_stall;
    logic [CHAR_W-1:0]   o_char_index;
    logic [COL_W-1:0]    o_start_col;
    logic [ECOL_W-1:0]   o_end_col;
    logic [ROW_W-1:0]    o_top_row;
    logic [EROW_W-1:0]   o_end_row;
    logic                o_open_at_edge;
    logic                i_cfg_wr_en;
    logic                i_cfg_index;
    logic [CFG_W-1:0]    i_cfg_wdata;

    span_tracker sb;
    int  gap_pct;
    int  stall_pct;
    bit  calm;
    int  stall_left;
    int  cycle_count;

    projection_char_segmenter_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_column_ink   (i_column_ink),
        .i_last_column  (i_last_column),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_char_index   (o_char_index),
        .o_start_col    (o_start_col),
        .o_end_col      (o_end_col),
        .o_top_row      (o_top_row),
        .o_end_row      (o_end_row),
        .o_open_at_edge (o_open_at_edge),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Random output stall, redrawn whenever the hold counter runs out
    always @(posedge i_clk) begin
        if (!i_rst_n || calm) begin
            i_out_stall <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
            stall_left = $urandom_range(0, 12);
        end
    end

    // Result monitor
    always @(posedge i_clk) begin : capture
        t_span seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.char_index = o_char_index;
            seen.start_col = o_start_col;
            seen.end_col = o_end_col;
            seen.top_row = o_top_row;
            seen.end_row = o_end_row;
            seen.open_edge = o_open_at_edge;
            sb.match_span(seen);
        end
    end

    task automatic send_column(input logic [INK_W-1:0] ink, input logic is_last);
        int gap;
        if (!calm && gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 13);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_column_ink <= ink;
        i_last_column <= is_last;
        do @(posedge i_clk); while (o_in_stall);
        sb.take_column(ink, is_last);
    endtask

    // Hold input until every expected span is back, then let the pipe settle
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_regs(input logic [COL_W-1:0] fc, input logic [EROW_W-1:0] rows);
        logic [CFG_W-1:0] rows_word;
        rows_word = {3'($urandom_range(0, 7)), rows};
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_FIRST_COLUMN;
        i_cfg_wdata <= fc;
        @(posedge i_clk);
        sb.write_reg(CFG_FIRST_COLUMN, fc);
        i_cfg_index <= CFG_ROWS_IN_USE;
        i_cfg_wdata <= rows_word;
        @(posedge i_clk);
        sb.write_reg(CFG_ROWS_IN_USE, rows_word);
        i_cfg_wr_en <= 1'b0;
    endtask

    // One stroke slice: a row band, mostly inside the height, sometimes a stray pixel
    function automatic logic [INK_W-1:0] glyph_column();
        int h, top, len;
        logic [INK_W-1:0] col;
        h = sb.height();
        top = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, h - 1);
        len = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
        col = '0;
        for (int r = top; r < INK_W && r < top + len; r++) col[r] = 1'b1;
        if ($urandom_range(0, 3) == 0) col[$urandom_range(0, 63)] = 1'b1;
        return col;
    endfunction

    task automatic send_page(input int width, input int shape);
        int run_left;
        bit inked;
        logic [INK_W-1:0] ink;
        inked = 0;
        run_left = $urandom_range(0, 3);
        for (int c = 0; c < width; c++) begin
            if (run_left == 0) begin
                inked = !inked;
                if (shape == PAGE_DENSE) begin
                    run_left = 1;
                end else begin
                    run_left = inked ? $urandom_range(1, 6) : $urandom_range(1, 4);
                end
            end
            run_left--;
            ink = inked ? glyph_column() : '0;
            if (shape == PAGE_NOISE || $urandom_range(0, 99) < 4) begin
                ink = {$urandom, $urandom};
            end
            send_column(ink, c == width - 1);
        end
    endtask

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0: return 0;
            1: return 10;
            2: return 30;
            default: return 60;
        endcase
    endfunction

    // One register setting, then short pages until the column budget is spent
    task automatic run_phase(input logic [COL_W-1:0] fc, input logic [EROW_W-1:0] rows,
                             input int budget, input int gp, input int sp);
        int sent, width, pick;
        wait_drained();
        write_regs(fc, rows);
        gap_pct = gp;
        stall_pct = sp;
        sent = 0;
        while (sent < budget) begin
            pick = $urandom_range(0, 9);
            width = $urandom_range(1, 40);
            if (pick == 0) begin
                send_page(width, PAGE_DENSE);
            end else if (pick == 1) begin
                send_page(width, PAGE_NOISE);
            end else begin
                send_page(width, PAGE_TEXT);
            end
            sent += width;
        end
    endtask

    initial begin
        sb = new();
        cycle_count = 0;
        calm = 0;
        gap_pct = 0;
        stall_pct = 0;
        stall_left = 0;
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_column_ink <= '0;
        i_last_column <= 1'b0;
        i_out_stall <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= CFG_FIRST_COLUMN;
        i_cfg_wdata <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings, column 0 skipped
        send_column('1, 1'b0);
        send_column(64'h1, 1'b0);
        send_column(64'h8000_0000_0000_0000, 1'b0);
        send_column('0, 1'b0);
        send_column('1, 1'b0);
        send_column('0, 1'b0);
        send_column(64'h3E0, 1'b1);
        // one-column page before the first scanned column, then open at edge
        send_column('1, 1'b1);
        send_column('0, 1'b0);
        send_column(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        // short height: ink above it is ignored, no empty row gives the height
        wait_drained();
        write_regs(COL_W'(0), EROW_W'(8));
        send_column(64'hFFFF_FFFF_FFFF_FF00, 1'b0);
        send_column(64'hF0, 1'b0);
        send_column(64'h1, 1'b0);
        send_column(64'hFF00, 1'b0);
        send_column(64'h80, 1'b1);

        // Random pages over several settings, extremes included
        run_phase(COL_W'(0), EROW_W'(64), 80, 30, 30);
        run_phase(COL_W'(2), EROW_W'(1), 50, 0, 50);
        run_phase(COL_W'(0), EROW_W'(0), 50, 50, 0);
        run_phase(COL_W'(1), EROW_W'(100), 50, 20, 20);
        run_phase(COL_W'(3), EROW_W'(127), 50, 10, 60);
        // many characters in one page: index saturates
        run_phase(COL_W'(0), EROW_W'(64), 30, 10, 10);
        send_page(140, PAGE_DENSE);
        // page longer than the column range: only the saturated index is scanned
        run_phase(COL_W'(1023), EROW_W'(64), 0, 0, 0);
        send_page(1032, PAGE_TEXT);
        for (int p = 0; p < 5; p++) begin
            run_phase(COL_W'($urandom_range(0, 6)), EROW_W'($urandom_range(1, 64)), 30,
                      pick_pct(), pick_pct());
        end
        // last stretch with no idling on either side
        calm = 1;
        run_phase(COL_W'(1), EROW_W'(64), 80, 0, 0);

        wait_drained();
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* projection_char_segmenter_core.f */
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_span.sv
hw/rtl/pcs_tracker.sv
hw/rtl/projection_char_segmenter_core.sv
bench/projection_char_segmenter_core_tb.sv
